// ===== rtl/ycc2rgb_pkg.sv =====
// shared types and constants for the ycbcr to rgbx converter
// no dependencies; imported by the config register, the datapath and the top level
`default_nettype none

package ycc2rgb_pkg;

    // byte order codes of the channel_order register
    typedef enum logic {
        ORDER_BGRX = 1'b0,
        ORDER_RGBX = 1'b1
    } order_t;

    // jfif matrix, fractional parts as signed 16-bit values with 16 fraction bits
    localparam logic signed [15:0] K_R_CR = 16'sd26345;
    localparam logic signed [15:0] K_B_CB = -16'sd14942;
    localparam logic signed [15:0] K_G_CB = -16'sd22554;
    localparam logic signed [15:0] K_G_CR = 16'sd18734;

    localparam logic [8:0]  CHROMA_BIAS = 9'd128;
    localparam logic [7:0]  ALPHA_BYTE  = 8'hFF;
    localparam logic signed [25:0] ROUND_HALF = 26'sd32768;

    // register map
    localparam logic REG_CHANNEL_ORDER = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/ycc2rgb_cfg.sv =====
// apb register file holding the channel_order register
// depends on ycc2rgb_pkg
`default_nettype none

module ycc2rgb_cfg
    import ycc2rgb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output order_t           channel_order
);

    order_t order_reg;
    order_t order_next;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CHANNEL_ORDER);

    always_comb
    begin
        order_next = order_reg;
        if (wr_en)
        begin
            order_next = order_t'(pwdata[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_BGRX;
        end
        else
        begin
            order_reg <= order_next;
        end
    end

    // unused address reads as zero
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_CHANNEL_ORDER)
        begin
            prdata = {31'd0, order_reg};
        end
    end

    assign channel_order = order_reg;

endmodule

`default_nettype wire

// ===== rtl/ycc2rgb_datapath.sv =====
// four-stage color matrix pipeline: bias, multiply, round, clamp and pack
// depends on ycc2rgb_pkg
`default_nettype none

module ycc2rgb_datapath
    import ycc2rgb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] luma,
    input  wire logic [7:0] chroma_blue,
    input  wire logic [7:0] chroma_red,
    input  wire order_t     channel_order,
    output logic            out_valid,
    output logic [31:0]     pixel_word
);

    // valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: centered chroma
    logic [7:0]        y1_reg;
    logic signed [8:0] cb1_reg, cr1_reg;
    logic signed [8:0] cb1_next, cr1_next;

    // stage 2: products
    logic [7:0]         y2_reg;
    logic signed [8:0]  cb2_reg, cr2_reg;
    logic signed [24:0] pr2_reg, pb2_reg, pgb2_reg, pgr2_reg;

    // stage 3: rounded offsets
    logic [7:0]         y3_reg;
    logic signed [10:0] ry3_reg, gy3_reg, by3_reg;
    logic signed [25:0] r_biased, b_biased, g_biased;
    logic signed [9:0]  r_rnd, b_rnd, g_rnd;
    logic signed [10:0] ry3_next, gy3_next, by3_next;

    // stage 4: clamp and pack
    logic signed [10:0] r_sum, g_sum, b_sum;
    logic [7:0]         r_u8, g_u8, b_u8;
    logic [31:0]        word_reg, word_next;

    function automatic logic [7:0] clamp_u8(input logic signed [10:0] v);
        if (v[10])
        begin
            return 8'd0;
        end
        else if (v[9:8] != 2'd0)
        begin
            return 8'hFF;
        end
        return v[7:0];
    endfunction

    assign cb1_next = $signed({1'b0, chroma_blue} - CHROMA_BIAS);
    assign cr1_next = $signed({1'b0, chroma_red} - CHROMA_BIAS);

    always_comb
    begin
        r_biased = 26'(pr2_reg) + ROUND_HALF;
        b_biased = 26'(pb2_reg) + ROUND_HALF;
        g_biased = 26'(pgb2_reg) + 26'(pgr2_reg) + ROUND_HALF;
        r_rnd    = r_biased[25:16];
        b_rnd    = b_biased[25:16];
        g_rnd    = g_biased[25:16];
        ry3_next = 11'(r_rnd) + 11'(cr2_reg);
        gy3_next = 11'(g_rnd) - 11'(cr2_reg);
        by3_next = 11'(b_rnd) + $signed({cb2_reg[8], cb2_reg, 1'b0});
    end

    always_comb
    begin
        r_sum = $signed({3'd0, y3_reg}) + ry3_reg;
        g_sum = $signed({3'd0, y3_reg}) + gy3_reg;
        b_sum = $signed({3'd0, y3_reg}) + by3_reg;
        r_u8  = clamp_u8(r_sum);
        g_u8  = clamp_u8(g_sum);
        b_u8  = clamp_u8(b_sum);
        if (channel_order == ORDER_RGBX)
        begin
            word_next = {ALPHA_BYTE, b_u8, g_u8, r_u8};
        end
        else
        begin
            word_next = {ALPHA_BYTE, r_u8, g_u8, b_u8};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        y1_reg   <= luma;
        cb1_reg  <= cb1_next;
        cr1_reg  <= cr1_next;

        y2_reg   <= y1_reg;
        cb2_reg  <= cb1_reg;
        cr2_reg  <= cr1_reg;
        pr2_reg  <= cr1_reg * K_R_CR;
        pb2_reg  <= cb1_reg * K_B_CB;
        pgb2_reg <= cb1_reg * K_G_CB;
        pgr2_reg <= cr1_reg * K_G_CR;

        y3_reg   <= y2_reg;
        ry3_reg  <= ry3_next;
        gy3_reg  <= gy3_next;
        by3_reg  <= by3_next;

        word_reg <= word_next;
    end

    assign out_valid  = v4_reg;
    assign pixel_word = word_reg;

endmodule

`default_nettype wire

// ===== rtl/ycbcr_to_rgbx_converter_top.sv =====
// top level of the ycbcr to packed rgbx/bgrx pixel converter
// depends on ycc2rgb_pkg, ycc2rgb_cfg and ycc2rgb_datapath
//
//   channel   handshake            payload
//   --------  -------------------  ---------------------------------------
//   request   start & !busy        luma[7:0], chroma_blue[7:0], chroma_red[7:0]
//   result    done (one cycle)     pixel_word[31:0]
//   config    apb psel/penable     paddr[2:0], pwdata[31:0], prdata[31:0]
//
// one request is taken every cycle; busy is never raised
// each result is registered through the four
// register stages: chroma bias, matrix multiply, rounding, clamp and pack
// rst_n clears the valid bits and resets channel_order to bgrx order
// the receiver cannot stall, so no request ever waits
`default_nettype none

module ycbcr_to_rgbx_converter_top
    import ycc2rgb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  luma,
    input  wire logic [7:0]  chroma_blue,
    input  wire logic [7:0]  chroma_red,
    // result channel
    output logic             done,
    output logic [31:0]      pixel_word,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    order_t channel_order;
    logic   accept;

    // fully pipelined, so the request side is always open
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // byte order register
    ycc2rgb_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .channel_order (channel_order)
    );

    // color matrix pipeline, valid travels alongside the data
    ycc2rgb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .luma          (luma),
        .chroma_blue   (chroma_blue),
        .chroma_red    (chroma_red),
        .channel_order (channel_order),
        .out_valid     (done),
        .pixel_word    (pixel_word)
    );

endmodule

`default_nettype wire
